>>> rtl/core/pses_pkg.sv
// shared constants, codes and handshake structs for the prefix expression evaluator
package pses_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int ST_W        = 3;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int OUT_TDATA_W = ((DATA_W + ST_W + 7) / 8) * 8;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  // token kinds
  localparam logic [OP_W-1:0] OP_NUM = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FEW      = 3'd1;
  localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

>>> rtl/core/pses_alu.sv
// shared arithmetic unit: registered add, subtract, multiply; bit-serial signed divide
module pses_alu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pses_pkg::alu_req_t       req,
  input  logic [pses_pkg::DATA_W-1:0] a,
  input  logic [pses_pkg::DATA_W-1:0] b,
  output pses_pkg::alu_rsp_t       rsp
);
  import pses_pkg::*;

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_FIX  = 3'b100
  } alu_state_t;

  alu_state_t            state_r, state_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_W-1:0]     res_r, res_nxt;
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     quo_r, quo_nxt;
  logic [DATA_W-1:0]     div_r, div_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [DATA_W-1:0]     mag_a, mag_b;
  logic [DATA_W:0]       shifted, diff;

  always_comb begin
    mag_a   = a[DATA_W-1] ? (~a + 1'b1) : a;
    mag_b   = b[DATA_W-1] ? (~b + 1'b1) : b;
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = shifted - {1'b0, div_r};
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      A_IDLE: begin
        if (req.start) begin
          case (req.op)
            OP_ADD: begin
              res_nxt  = a + b;
              done_nxt = 1'b1;
            end
            OP_SUB: begin
              res_nxt  = a - b;
              done_nxt = 1'b1;
            end
            OP_MUL: begin
              res_nxt  = a * b;
              done_nxt = 1'b1;
            end
            default: begin
              // restoring division on magnitudes, sign applied at the end
              rem_nxt   = '0;
              quo_nxt   = mag_a;
              div_nxt   = mag_b;
              neg_nxt   = a[DATA_W-1] ^ b[DATA_W-1];
              cnt_nxt   = DIV_CNT_W'(DATA_W - 1);
              state_nxt = A_DIV;
            end
          endcase
        end
      end
      A_DIV: begin
        if (!diff[DATA_W]) begin
          rem_nxt = diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        res_nxt   = neg_r ? (~quo_r + 1'b1) : quo_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

>>> rtl/core/prefix_expression_stack_evaluator_top.sv
// prefix expression evaluator: token sequencer, operand stack memory and result register
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata value, tuser op, tlast end of expr
//  out_    | out | out_tvalid/out_tready| tdata result[31:0], status[34:32]
//
// number tokens run the exec and finish states; operators also read two operands and
// wait on the alu (one quotient bit per cycle for divide); a last token adds a top read.
// the stack memory has one write and one registered read port, used once per step.
// in_tready is high only while the sequencer is idle; a pending result waits in the
// output register and only a last token whose report finds it still full stalls.
// reset clears the stack pointer and error latch; stack contents need no clearing.
module prefix_expression_stack_evaluator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pses_pkg::DATA_W-1:0]       in_tdata,   // value
  input  logic [pses_pkg::OP_W-1:0]         in_tuser,   // op
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pses_pkg::OUT_TDATA_W-1:0]  out_tdata   // result, status, zero fill
);
  import pses_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_RDA    = 7'b0000100,
    S_RDB    = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_REPORT = 7'b1000000
  } seq_state_t;

  seq_state_t           state_r, state_nxt;
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [ST_W-1:0]      err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]      op_r, op_nxt;
  logic [DATA_W-1:0]    value_r, value_nxt;
  logic                 last_r, last_nxt;
  logic [DATA_W-1:0]    a_r, a_nxt;
  logic [DATA_W-1:0]    out_result_r, out_result_nxt;
  logic [ST_W-1:0]      out_status_r, out_status_nxt;

  logic [DATA_W-1:0]    stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0]    rd_data_r;
  logic                 wr_en, rd_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [DATA_W-1:0]    wr_data;
  logic [SP_W-1:0]      sp_dec;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  pses_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (a_r),
    .b     (rd_data_r),
    .rsp   (alu_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DATA_W - ST_W){1'b0}}, out_status_r, out_result_r};
  assign sp_dec     = sp_r - 1'b1;

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    op_nxt         = op_r;
    value_nxt      = value_r;
    last_nxt       = last_r;
    a_nxt          = a_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = sp_r[ADDR_W-1:0];
    wr_data        = value_r;
    rd_en          = 1'b0;
    rd_addr        = sp_dec[ADDR_W-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          value_nxt = in_tdata;
          last_nxt  = in_tlast;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        if (err_r == ST_OK && op_r <= OP_DIV) begin
          if (op_r == OP_NUM) begin
            if (sp_r == SP_W'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              wr_en  = 1'b1;
              sp_nxt = sp_r + 1'b1;
            end
          end else if (sp_r == '0) begin
            err_nxt = ST_FEW;
          end else begin
            rd_en     = 1'b1;
            sp_nxt    = sp_dec;
            state_nxt = S_RDA;
          end
        end
      end
      S_RDA: begin
        a_nxt = rd_data_r;
        if (sp_r == '0) begin
          err_nxt   = ST_FEW;
          state_nxt = S_FINISH;
        end else begin
          rd_en     = 1'b1;
          sp_nxt    = sp_dec;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        if (op_r == OP_DIV && rd_data_r == '0) begin
          err_nxt   = ST_DIVZERO;
          state_nxt = S_FINISH;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          wr_en     = 1'b1;
          wr_data   = alu_rsp.result;
          sp_nxt    = sp_r + 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (last_r) begin
          // fetch the top entry for the report
          rd_en     = 1'b1;
          state_nxt = S_REPORT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REPORT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          out_result_nxt = '0;
          if (err_r == ST_OK) begin
            if (sp_r == '0) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              out_result_nxt = rd_data_r;
            end
          end
          sp_nxt    = '0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    last_r       <= last_nxt;
    a_r          <= a_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  // operand stack: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

endmodule

>>> bench/testbench.sv
// testbench for the prefix expression evaluator: token stimulus, stack predictor, report checks
`timescale 1ns / 100ps

module testbench;
  import pses_pkg::*;

  // token kinds the block leaves without effect
  localparam logic [OP_W-1:0] OP_NOP_A = 3'd5;
  localparam logic [OP_W-1:0] OP_NOP_B = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP_C = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] result;
    logic [ST_W-1:0]   status;
  } report_t;

  class expr_scoreboard;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       depth;
    logic [ST_W-1:0]   latched;
    report_t           pending [$];
    int unsigned       failures;
    int unsigned       reports_seen;
    int unsigned       error_reports;

    function new();
      depth = 0;
      latched = ST_OK;
      failures = 0;
      reports_seen = 0;
      error_reports = 0;
    endfunction

    function logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] ma, mb, q;
      ma = a[DATA_W-1] ? -a : a;
      mb = b[DATA_W-1] ? -b : b;
      q = ma / mb;
      return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
    endfunction

    function void apply_operator(logic [OP_W-1:0] op);
      logic [DATA_W-1:0] a, b, r;
      if (depth == 0) begin
        latched = ST_FEW;
        return;
      end
      depth--;
      a = operands[depth];
      // the first operand stays popped
      if (depth == 0) begin
        latched = ST_FEW;
        return;
      end
      depth--;
      b = operands[depth];
      case (op)
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = a * b;
        default: begin
          if (b == '0) begin
            latched = ST_DIVZERO;
            return;
          end
          r = signed_quotient(a, b);
        end
      endcase
      operands[depth] = r;
      depth++;
    endfunction

    function void take_token(logic [OP_W-1:0] op, logic [DATA_W-1:0] value, logic last);
      report_t rep;
      if (latched == ST_OK) begin
        if (op == OP_NUM) begin
          if (depth >= STACK_DEPTH) latched = ST_OVERFLOW;
          else begin
            operands[depth] = value;
            depth++;
          end
        end else if (op <= OP_DIV) begin
          apply_operator(op);
        end
      end
      if (last) begin
        rep.status = latched;
        rep.result = '0;
        if (latched == ST_OK) begin
          if (depth == 0) rep.status = ST_EMPTY;
          else rep.result = operands[depth-1];
        end
        pending.push_back(rep);
        depth = 0;
        latched = ST_OK;
      end
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] word);
      report_t           want;
      logic [DATA_W-1:0] got_result;
      logic [ST_W-1:0]   got_status;
      got_result = word[DATA_W-1:0];
      got_status = word[DATA_W +: ST_W];
      reports_seen++;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected report, result %h status %0d", got_result, got_status);
        return;
      end
      want = pending.pop_front();
      if (want.status != ST_OK) error_reports++;
      if (got_result !== want.result || got_status !== want.status ||
          word[OUT_TDATA_W-1:DATA_W+ST_W] !== '0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: report %0d expected result %h status %0d, got result %h status %0d fill %h",
                   reports_seen, want.result, want.status, got_result, got_status,
                   word[OUT_TDATA_W-1:DATA_W+ST_W]);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = OP_NUM;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  expr_scoreboard sb;
  int unsigned    tokens_sent = 0;
  int unsigned    quiet_tokens = 0;
  int unsigned    ready_hold = 0;
  int unsigned    ready_calm = 0;

  prefix_expression_stack_evaluator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 14) return 32'h8000_0000;
    if (roll < 18) return 32'h7FFF_FFFF;
    if (roll < 22) return 32'hFFFF_FFFF;
    if (roll < 60) return $urandom_range(0, 40) - 20;
    return $urandom;
  endfunction

  // result side: random stalls, with stretches of steady readiness
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (ready_calm != 0) ready_calm <= ready_calm - 1;
      else if ($urandom_range(0, 99) == 0) ready_calm <= $urandom_range(50, 300);
      else if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.take_token(in_tuser, in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
  end

  task automatic send_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                            input logic last);
    int unsigned gap;
    gap = (quiet_tokens != 0) ? 0 : pick_gap();
    if (quiet_tokens != 0) quiet_tokens--;
    else if ($urandom_range(0, 199) == 0) quiet_tokens = $urandom_range(40, 120);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokens_sent++;
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // well-formed expression in right-to-left order; op_percent steers how early operators fold
  task automatic send_expression(input int unsigned operands_total, input int unsigned op_percent);
    int unsigned     held;
    int unsigned     left;
    logic [OP_W-1:0] op;
    held = 0;
    left = operands_total;
    while (left != 0 || held > 1) begin
      if (held >= 2 && (left == 0 || $urandom_range(1, 100) <= op_percent)) begin
        op = OP_W'($urandom_range(OP_ADD, OP_DIV));
        held--;
        send_token(op, $urandom, left == 0 && held == 1);
      end else begin
        held++;
        left--;
        send_token(OP_NUM, pick_operand(), left == 0 && held == 1);
      end
    end
  endtask

  task automatic send_noise(input int unsigned count);
    for (int unsigned k = 1; k <= count; k++)
      send_token(OP_W'($urandom_range(OP_NUM, OP_NOP_C)), $urandom,
                 k == count || $urandom_range(0, 5) == 0);
  endtask

  initial begin
    int unsigned target;
    int unsigned roll;
    bit          paused;
    sb = new();
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // add, subtract and multiply, wrapping at the extremes
    send_token(OP_NUM, 32'd4, 1'b0);
    send_token(OP_NUM, 32'd3, 1'b0);
    send_token(OP_ADD, 32'd0, 1'b1);
    send_token(OP_NUM, 32'hFFFF_FFFF, 1'b0);
    send_token(OP_NUM, 32'h7FFF_FFFF, 1'b0);
    send_token(OP_SUB, 32'hFFFF_FFFF, 1'b1);
    send_token(OP_NUM, 32'h8000_0000, 1'b0);
    send_token(OP_NUM, 32'h7FFF_FFFF, 1'b0);
    send_token(OP_MUL, 32'd0, 1'b1);
    // truncation toward zero, then most negative over minus one
    send_token(OP_NUM, 32'hFFFF_FFFD, 1'b0);
    send_token(OP_NUM, 32'd7, 1'b0);
    send_token(OP_DIV, 32'd0, 1'b1);
    send_token(OP_NUM, 32'hFFFF_FFFF, 1'b0);
    send_token(OP_NUM, 32'h8000_0000, 1'b0);
    send_token(OP_DIV, 32'd0, 1'b1);
    // zero divisor latches and the following number is ignored
    send_token(OP_NUM, 32'd0, 1'b0);
    send_token(OP_NUM, 32'd5, 1'b0);
    send_token(OP_DIV, 32'd0, 1'b0);
    send_token(OP_NUM, 32'd9, 1'b1);
    // operator on an empty stack, then on a single operand
    send_token(OP_ADD, 32'd0, 1'b1);
    send_token(OP_NUM, 32'd1, 1'b0);
    send_token(OP_MUL, 32'd0, 1'b0);
    send_token(OP_NUM, 32'd2, 1'b1);
    // unused kinds: empty report, and the top passes through untouched
    send_token(OP_NOP_A, 32'd0, 1'b1);
    send_token(OP_NUM, 32'h5555_5555, 1'b0);
    send_token(OP_NOP_B, 32'd0, 1'b0);
    send_token(OP_NOP_C, 32'hFFFF_FFFF, 1'b1);
    // leftover operands report the top
    send_token(OP_NUM, 32'd1, 1'b0);
    send_token(OP_NUM, 32'd2, 1'b0);
    send_token(OP_NUM, 32'hAAAA_AAAA, 1'b1);
    // full stack folded back down, then one push past the top
    send_expression(STACK_DEPTH, 0);
    for (int unsigned k = 0; k < STACK_DEPTH; k++) send_token(OP_NUM, k, 1'b0);
    send_token(OP_NUM, 32'd99, 1'b1);
    wait_for_reports();

    target = tokens_sent + 1000;
    while (tokens_sent < target) begin
      if (!paused && tokens_sent > target - 500) begin
        wait_for_reports();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 1) send_expression(STACK_DEPTH + 1, 0);
      else if (roll < 3) send_expression(STACK_DEPTH, $urandom_range(0, 30));
      else if (roll < 18) send_noise($urandom_range(1, 8));
      else send_expression($urandom_range(1, 8), $urandom_range(20, 80));
    end

    wait_for_reports();
    repeat (60) @(posedge clk);
    $display("run covered %0d tokens and %0d reports, %0d of them with an error status",
             tokens_sent, sb.reports_seen, sb.error_reports);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d reports missing", sb.failures, sb.pending.size());
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d reports still pending", sb.pending.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
